[src/btpe_pkg.sv]
`timescale 1ns / 1ps
// shared types, constants and helpers for the bicorn torus point evaluator
// no dependencies; imported by the cordic cell, the divider cell and the top module
package btpe_pkg;

    localparam int CORDIC_STEPS = 28;
    localparam int DIV_STEPS    = 28;
    localparam int CW           = 33;   // cordic x/y/z word
    localparam int TW           = 32;   // sin/cos, q30 clamped to +-1.0
    localparam int REG_W        = 24;
    localparam int OUT_W        = 25;
    localparam int REM_W        = 60;   // divider dividend / remainder
    localparam int DEN_W        = 33;   // divider divisor

    typedef logic signed [CW-1:0] cord_word_t;

    typedef struct packed {
        cord_word_t x;
        cord_word_t y;
        cord_word_t z;
        logic [1:0] quad;
    } cordic_t;

    typedef struct packed {
        logic [REM_W-1:0]     rem;
        logic [DEN_W-1:0]     den;
        logic [DIV_STEPS-1:0] quo;
    } div_t;

    typedef enum logic {
        REG_MAJOR = 1'b0,
        REG_MINOR = 1'b1
    } reg_idx_t;

    localparam cord_word_t CORDIC_GAIN = 33'sd652032874;

    // arctangent of 2^-i in units of 2^-32 turn
    localparam logic [31:0] ATAN_TABLE [CORDIC_STEPS] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
        32'd21354465,  32'd10679838,  32'd5340245,   32'd2670163,  32'd1335087,
        32'd667544,    32'd333772,    32'd166886,    32'd83443,    32'd41722,
        32'd20861,     32'd10430,     32'd5215,      32'd2608,     32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,       32'd41,
        32'd20,        32'd10,        32'd5
    };

    localparam logic signed [63:0] OUT_MAX = 64'sd16777215;
    localparam logic signed [63:0] OUT_MIN = -64'sd16777216;

    function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [63:0] v);
        logic signed [OUT_W-1:0] r;
        if (v > OUT_MAX)
            r = OUT_MAX[OUT_W-1:0];
        else if (v < OUT_MIN)
            r = OUT_MIN[OUT_W-1:0];
        else
            r = v[OUT_W-1:0];
        return r;
    endfunction

endpackage

[src/btpe_cordic_cell.sv]
`timescale 1ns / 1ps
// one registered cordic rotation step for a fixed iteration index
// depends on btpe_pkg
module btpe_cordic_cell
    import btpe_pkg::*;
#(
    parameter int STEP = 0
)
(
    input  logic    clk,
    input  cordic_t cell_in,
    output cordic_t cell_out
);

    localparam cord_word_t ATAN = cord_word_t'({1'b0, ATAN_TABLE[STEP]});

    cordic_t cell_reg;
    cordic_t cell_next;
    cord_word_t dx;
    cord_word_t dy;

    always_comb
    begin
        dx = cell_in.y >>> STEP;
        dy = cell_in.x >>> STEP;
        cell_next.quad = cell_in.quad;
        if (!cell_in.z[CW-1])
        begin
            cell_next.x = cell_in.x - dx;
            cell_next.y = cell_in.y + dy;
            cell_next.z = cell_in.z - ATAN;
        end
        else
        begin
            cell_next.x = cell_in.x + dx;
            cell_next.y = cell_in.y - dy;
            cell_next.z = cell_in.z + ATAN;
        end
    end

    always_ff @(posedge clk)
    begin
        cell_reg <= cell_next;
    end

    assign cell_out = cell_reg;

endmodule

[src/btpe_div_cell.sv]
`timescale 1ns / 1ps
// one registered restoring division step producing quotient bit SHIFT
// depends on btpe_pkg
module btpe_div_cell
    import btpe_pkg::*;
#(
    parameter int SHIFT = 0
)
(
    input  logic clk,
    input  div_t cell_in,
    output div_t cell_out
);

    div_t cell_reg;
    div_t cell_next;
    logic [REM_W:0] trial;
    logic           fits;

    always_comb
    begin
        trial = {1'b0, cell_in.rem}
              - ({{(REM_W-DEN_W+1){1'b0}}, cell_in.den} << SHIFT);
        fits  = !trial[REM_W];
        cell_next = cell_in;
        cell_next.quo[SHIFT] = fits;
        if (fits)
            cell_next.rem = trial[REM_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        cell_reg <= cell_next;
    end

    assign cell_out = cell_reg;

endmodule

[src/bicorn_torus_point_eval.sv]
`timescale 1ns / 1ps
// done strobes with each result once its start transaction has passed the whole pipeline
// throughput: one transaction per cycle, busy never rises; the receiver cannot stall
// pipeline length is set mainly by the 28-cell cordic chain and the 28-cell divider chain
// reset (rst_n, async, active low) flushes all in-flight transactions and
// loads R = 2.0 and r = 1.0; the datapath holds no state between points
module bicorn_torus_point_eval
    import btpe_pkg::*;
#(
    parameter int ANGLE_BITS = 16
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    // command side
    input  logic                    start,
    output logic                    busy,
    input  logic [ANGLE_BITS-1:0]   u_angle,
    input  logic [ANGLE_BITS-1:0]   v_angle,
    // result side
    output logic                    done,
    output logic signed [OUT_W-1:0] x_out,
    output logic signed [OUT_W-1:0] y_out,
    output logic signed [OUT_W-1:0] z_out,
    // configuration write port
    input  logic                    cfg_we,
    input  logic [0:0]              cfg_index,
    input  logic [REG_W-1:0]        cfg_data
);

    // register stages: cordic chain, fold, four arithmetic stages, divider chain,
    // final multiply, output
    localparam int SIDE_DEPTH = 4 + DIV_STEPS;
    localparam int LATENCY    = CORDIC_STEPS + 1 + SIDE_DEPTH + 2;

    typedef struct packed {
        logic signed [TW-1:0]    cu;
        logic signed [TW-1:0]    su;
        logic signed [OUT_W-1:0] y;
        logic                    neg;
    } side_t;

    // ---------------- configuration registers ----------------
    logic signed [REG_W-1:0] major_reg;
    logic signed [REG_W-1:0] minor_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            major_reg <= 24'sd131072;
            minor_reg <= 24'sd65536;
        end
        else if (cfg_we)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_MAJOR: major_reg <= cfg_data;
                REG_MINOR: minor_reg <= cfg_data;
                default:   ;
            endcase
        end
    end

    // ---------------- transaction tracking ----------------
    // the pipeline always advances, so a plain shift line of valid bits suffices
    logic [LATENCY-1:0] vld_reg;
    logic               accept;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[LATENCY-2:0], accept};
    end

    assign done = vld_reg[LATENCY-1];

    // ---------------- cordic chains for u and v ----------------
    // the top two phase bits pick the quadrant, the rest is rotated in the chain
    cordic_t u_chain [CORDIC_STEPS+1];
    cordic_t v_chain [CORDIC_STEPS+1];

    always_comb
    begin
        u_chain[0].x    = CORDIC_GAIN;
        u_chain[0].y    = '0;
        u_chain[0].z    = cord_word_t'({u_angle[ANGLE_BITS-3:0], {(32-ANGLE_BITS){1'b0}}});
        u_chain[0].quad = u_angle[ANGLE_BITS-1 -: 2];
        v_chain[0].x    = CORDIC_GAIN;
        v_chain[0].y    = '0;
        v_chain[0].z    = cord_word_t'({v_angle[ANGLE_BITS-3:0], {(32-ANGLE_BITS){1'b0}}});
        v_chain[0].quad = v_angle[ANGLE_BITS-1 -: 2];
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_cordic
        btpe_cordic_cell #(.STEP(i)) u_cell_u (
            .clk      (clk),
            .cell_in  (u_chain[i]),
            .cell_out (u_chain[i+1])
        );
        btpe_cordic_cell #(.STEP(i)) u_cell_v (
            .clk      (clk),
            .cell_in  (v_chain[i]),
            .cell_out (v_chain[i+1])
        );
    end

    // ---------------- quadrant fold with clamp to +-1.0 ----------------
    function automatic logic signed [TW-1:0] clamp_trig(input cord_word_t v);
        logic signed [TW-1:0] r;
        if (v > 33'sd1073741824)
            r = 32'sd1073741824;
        else if (v < -33'sd1073741824)
            r = -32'sd1073741824;
        else
            r = v[TW-1:0];
        return r;
    endfunction

    logic signed [TW-1:0] ux;
    logic signed [TW-1:0] uy;
    logic signed [TW-1:0] vx;
    logic signed [TW-1:0] vy;
    logic signed [TW-1:0] cu_next;
    logic signed [TW-1:0] su_next;
    logic signed [TW-1:0] cv_next;
    logic signed [TW-1:0] sv_next;
    logic signed [TW-1:0] cu_reg;
    logic signed [TW-1:0] su_reg;
    logic signed [TW-1:0] cv_reg;
    logic signed [TW-1:0] sv_reg;

    always_comb
    begin
        ux = clamp_trig(u_chain[CORDIC_STEPS].x);
        uy = clamp_trig(u_chain[CORDIC_STEPS].y);
        vx = clamp_trig(v_chain[CORDIC_STEPS].x);
        vy = clamp_trig(v_chain[CORDIC_STEPS].y);
        unique case (u_chain[CORDIC_STEPS].quad)
            2'd0:    begin cu_next = ux;  su_next = uy;  end
            2'd1:    begin cu_next = -uy; su_next = ux;  end
            2'd2:    begin cu_next = -ux; su_next = -uy; end
            default: begin cu_next = uy;  su_next = -ux; end
        endcase
        unique case (v_chain[CORDIC_STEPS].quad)
            2'd0:    begin cv_next = vx;  sv_next = vy;  end
            2'd1:    begin cv_next = -vy; sv_next = vx;  end
            2'd2:    begin cv_next = -vx; sv_next = -vy; end
            default: begin cv_next = vy;  sv_next = -vx; end
        endcase
    end

    always_ff @(posedge clk)
    begin
        cu_reg <= cu_next;
        su_reg <= su_next;
        cv_reg <= cv_next;
        sv_reg <= sv_next;
    end

    // ---------------- stage 1: c*c and y = r*sin v ----------------
    // q30 products round half toward plus infinity
    logic signed [61:0] cc_prod;
    logic signed [54:0] y_prod;
    logic signed [55:0] y_rnd;
    logic signed [31:0] cc_next;
    logic signed [31:0] cc_reg;
    logic signed [TW-1:0] cv1_reg;
    side_t side_next;
    side_t side_reg [SIDE_DEPTH];

    always_comb
    begin
        cc_prod = cv_reg * cv_reg;
        cc_next = 32'((cc_prod + 62'sd536870912) >>> 30);
        y_prod  = minor_reg * sv_reg;
        y_rnd   = (56'(y_prod) + 56'sd536870912) >>> 30;
        side_next.cu  = cu_reg;
        side_next.su  = su_reg;
        side_next.y   = sat_out(64'(y_rnd));
        side_next.neg = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        cc_reg  <= cc_next;
        cv1_reg <= cv_reg;
    end

    // ---------------- stage 2: r*c*c and divisor 4 - c*c ----------------
    logic signed [55:0]   rcc_prod;
    logic signed [25:0]   rcc_next;
    logic signed [25:0]   rcc_reg;
    logic [DEN_W-1:0]     den_next;
    logic [DEN_W-1:0]     den2_reg;
    logic signed [TW-1:0] cv2_reg;

    always_comb
    begin
        rcc_prod = minor_reg * cc_reg;
        rcc_next = 26'((rcc_prod + 56'sd536870912) >>> 30);
        den_next = {1'b1, 32'd0} - {1'b0, cc_reg};
    end

    always_ff @(posedge clk)
    begin
        rcc_reg  <= rcc_next;
        den2_reg <= den_next;
        cv2_reg  <= cv1_reg;
    end

    // ---------------- stage 3: numerator (R + r*c*c)*(2 + c) ----------------
    logic signed [26:0]    sum_w;
    logic signed [32:0]    factor;
    logic signed [59:0]    num_next;
    logic signed [59:0]    num_reg;
    logic [DEN_W-1:0]      den3_reg;

    always_comb
    begin
        sum_w    = 27'(major_reg) + 27'(rcc_reg);
        factor   = 33'sh080000000 + 33'(cv2_reg);
        num_next = sum_w * factor;
    end

    always_ff @(posedge clk)
    begin
        num_reg  <= num_next;
        den3_reg <= den2_reg;
    end

    // ---------------- stage 4: magnitude plus half divisor ----------------
    // rounds the quotient to nearest, ties away from zero
    logic [REM_W-1:0] mag;
    div_t             div_chain [DIV_STEPS+1];
    div_t             div_next;
    div_t             div_reg;
    side_t            side3_next;

    always_comb
    begin
        mag = num_reg[59] ? REM_W'(-num_reg) : REM_W'(num_reg);
        div_next.rem = mag + REM_W'(den3_reg >> 1);
        div_next.den = den3_reg;
        div_next.quo = '0;
    end

    always_ff @(posedge clk)
    begin
        div_reg <= div_next;
    end

    assign div_chain[0] = div_reg;

    for (genvar i = 0; i < DIV_STEPS; i++)
    begin : g_div
        btpe_div_cell #(.SHIFT(DIV_STEPS-1-i)) u_div_cell (
            .clk      (clk),
            .cell_in  (div_chain[i]),
            .cell_out (div_chain[i+1])
        );
    end

    // sign of the numerator joins the line at the stage it is known
    always_comb
    begin
        side3_next     = side_reg[2];
        side3_next.neg = num_reg[59];
    end

    // sideband line alongside stages 1..4 and the divider chain
    always_ff @(posedge clk)
    begin
        side_reg[0] <= side_next;
        for (int k = 1; k < SIDE_DEPTH; k++)
        begin
            if (k == 3)
                side_reg[k] <= side3_next;
            else
                side_reg[k] <= side_reg[k-1];
        end
    end

    // ---------------- stage 5: x = cos u * w, z = sin u * w ----------------
    logic signed [DIV_STEPS:0] w;
    logic signed [59:0]        xp;
    logic signed [59:0]        zp;
    logic signed [29:0]        x_next;
    logic signed [29:0]        z_next;
    logic signed [29:0]        x_reg;
    logic signed [29:0]        z_reg;
    logic signed [OUT_W-1:0]   y_reg;
    side_t                     side_last;

    always_comb
    begin
        side_last = side_reg[SIDE_DEPTH-1];
        w = side_last.neg ? -$signed({1'b0, div_chain[DIV_STEPS].quo})
                          : $signed({1'b0, div_chain[DIV_STEPS].quo});
        xp = side_last.cu * w;
        zp = side_last.su * w;
        x_next = 30'((xp + 60'sd536870912) >>> 30);
        z_next = 30'((zp + 60'sd536870912) >>> 30);
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        z_reg <= z_next;
        y_reg <= side_last.y;
    end

    // ---------------- output registers with saturation ----------------
    always_ff @(posedge clk)
    begin
        x_out <= sat_out(64'(x_reg));
        y_out <= y_reg;
        z_out <= sat_out(64'(z_reg));
    end

endmodule

[src/btpe_checker.sv]
`timescale 1ns / 1ps
// port-level checker for the bicorn torus point evaluator, with its bind
// depends on bicorn_torus_point_eval
module btpe_checker #(
    parameter int LATENCY = 63
)
(
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done,
    input logic [24:0] x_out,
    input logic [24:0] y_out,
    input logic [24:0] z_out
);

    // every result traces back to a transaction taken a fixed time earlier
    a_done_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LATENCY))
        else $error("result without matching start transaction");

    // the pipeline never refuses a transaction
    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !busy)
        else $error("busy raised");

    // a strobed result carries defined data
    a_result_known: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !$isunknown({x_out, y_out, z_out}))
        else $error("result carries unknown bits");

endmodule

bind bicorn_torus_point_eval btpe_checker #(.LATENCY(63)) u_btpe_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done),
    .x_out (x_out),
    .y_out (y_out),
    .z_out (z_out)
);
